// File: design/fpsa_pkg.sv
// shared types, codes and defaults of the fit policy segment allocator
package fpsa_pkg;

   localparam int SEGMENTS_DEF  = 8;
   localparam int POOL_SIZE_DEF = 1024;
   localparam int ADDR_W        = 16;
   localparam int ENTRY_W       = 2 * ADDR_W;

   localparam logic [1:0] POLICY_FIRST = 2'd0;
   localparam logic [1:0] POLICY_BEST  = 2'd1;
   localparam logic [1:0] POLICY_WORST = 2'd2;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_NOFIT = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   localparam logic ACTION_ALLOC = 1'b0;
   localparam logic ACTION_LOAD  = 1'b1;

   typedef struct packed {
      logic              action;
      logic [ADDR_W-1:0] alloc_units;
      logic [ADDR_W-1:0] segment_base;
      logic [ADDR_W-1:0] segment_length;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [ADDR_W-1:0] grant_address;
      logic [3:0]        segments_left;
   } rsp_type;

   typedef struct packed {
      logic init_wr;
      logic capture;
      logic scan;
      logic carve;
      logic shift;
      logic respond;
   } ctl_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic found;
      logic drop;
      logic shift_done;
   } ctl_sts_type;

endpackage

// File: design/fpsa_ram.sv
// generic single write, single read ram with registered read data
module fpsa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/fpsa_ctrl.sv
// controller state machine of the segment allocator
module fpsa_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                start_load,
   input  fpsa_pkg::ctl_sts_type sts,
   output fpsa_pkg::ctl_cmd_type cmd,
   output logic                busy
);
   import fpsa_pkg::*;

   localparam logic [2:0] ST_INIT  = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_CARVE = 3'd3;
   localparam logic [2:0] ST_SHIFT = 3'd4;
   localparam logic [2:0] ST_RESP  = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_INIT: begin
            cmd.init_wr = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = (start_load == ACTION_LOAD) ? ST_RESP : ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) begin
               state_in = ST_CARVE;
            end
         end
         ST_CARVE: begin
            cmd.carve = 1'b1;
            state_in  = (sts.found && sts.drop) ? ST_SHIFT : ST_RESP;
         end
         ST_SHIFT: begin
            cmd.shift = 1'b1;
            if (sts.shift_done) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            cmd.respond = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// File: design/fpsa_dp.sv
// datapath of the segment allocator: table ram, scan, carve and shift-down
module fpsa_dp #(
   parameter int SEGMENTS  = fpsa_pkg::SEGMENTS_DEF,
   parameter int POOL_SIZE = fpsa_pkg::POOL_SIZE_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  fpsa_pkg::ctl_cmd_type cmd,
   output fpsa_pkg::ctl_sts_type sts,
   input  fpsa_pkg::req_type     req_data,
   input  logic                  csr_we,
   input  logic [1:0]            csr_data,
   output logic                  rsp_valid,
   output fpsa_pkg::rsp_type     rsp_data
);
   import fpsa_pkg::*;

   localparam int AW = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
   localparam int CW = $clog2(SEGMENTS + 1);

   logic [1:0]         policy_ff;
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      count_in;
   req_type            item_ff;

   logic [CW-1:0]      idx_ff;
   logic               ev_valid_ff;
   logic [AW-1:0]      ev_idx_ff;
   logic               found_ff;
   logic [AW-1:0]      pick_idx_ff;
   logic [ADDR_W-1:0]  pick_start_ff;
   logic [ADDR_W-1:0]  pick_size_ff;

   logic [CW-1:0]      sh_idx_ff;
   logic               sh_valid_ff;
   logic [AW-1:0]      sh_dst_ff;

   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic [AW-1:0]      rd_addr;
   logic [ENTRY_W-1:0] rd_data;

   logic [ADDR_W-1:0]  ent_start;
   logic [ADDR_W-1:0]  ent_size;
   logic               take;
   logic               scan_more;
   logic               shift_more;
   logic [ADDR_W-1:0]  remain;
   logic               load_full;
   logic               load_ok;
   rsp_type            rsp_in;

   fpsa_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SEGMENTS),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign ent_start  = rd_data[ENTRY_W-1:ADDR_W];
   assign ent_size   = rd_data[ADDR_W-1:0];
   assign scan_more  = (idx_ff < count_ff);
   assign shift_more = (sh_idx_ff < count_ff);
   assign remain     = pick_size_ff - item_ff.alloc_units;
   assign load_full  = (count_ff >= CW'(SEGMENTS));
   assign load_ok    = (item_ff.segment_length != '0) && !load_full;

   // earlier entries win ties, unknown policy codes behave as first fit
   assign take = ev_valid_ff && (ent_size >= item_ff.alloc_units) &&
                 (!found_ff ||
                  ((policy_ff == POLICY_BEST) && (ent_size < pick_size_ff)) ||
                  ((policy_ff == POLICY_WORST) && (ent_size > pick_size_ff)));

   assign sts.scan_done  = !scan_more && !ev_valid_ff;
   assign sts.found      = found_ff;
   assign sts.drop       = (remain == '0);
   assign sts.shift_done = !shift_more && !sh_valid_ff;

   always_comb begin
      rd_addr = '0;
      if (cmd.scan && scan_more) begin
         rd_addr = idx_ff[AW-1:0];
      end else if (cmd.shift && shift_more) begin
         rd_addr = sh_idx_ff[AW-1:0];
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = rd_data;
      priority if (cmd.init_wr) begin
         wr_en   = 1'b1;
         wr_data = {ADDR_W'(0), ADDR_W'(POOL_SIZE)};
      end else if (cmd.respond && (item_ff.action == ACTION_LOAD) && load_ok) begin
         wr_en   = 1'b1;
         wr_addr = count_ff[AW-1:0];
         wr_data = {item_ff.segment_base, item_ff.segment_length};
      end else if (cmd.carve && found_ff && (remain != '0)) begin
         wr_en   = 1'b1;
         wr_addr = pick_idx_ff;
         wr_data = {pick_start_ff + item_ff.alloc_units, remain};
      end else if (cmd.shift && sh_valid_ff) begin
         wr_en   = 1'b1;
         wr_addr = sh_dst_ff;
         wr_data = rd_data;
      end
   end

   always_comb begin
      count_in = count_ff;
      rsp_in   = '0;
      if (item_ff.action == ACTION_LOAD) begin
         if (load_ok) begin
            count_in = count_ff + CW'(1);
         end
         rsp_in.status = ((item_ff.segment_length != '0) && load_full) ?
                         STATUS_FULL : STATUS_DONE;
      end else if (found_ff) begin
         if (remain == '0) begin
            count_in = count_ff - CW'(1);
         end
         rsp_in.status        = STATUS_DONE;
         rsp_in.grant_address = pick_start_ff;
      end else begin
         rsp_in.status = STATUS_NOFIT;
      end
      rsp_in.segments_left = 4'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff    <= POLICY_FIRST;
         count_ff     <= CW'(1);
         ev_valid_ff  <= 1'b0;
         sh_valid_ff  <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            policy_ff <= csr_data;
         end
         rsp_valid_ff <= cmd.respond;
         if (cmd.respond) begin
            count_ff <= count_in;
         end
         if (cmd.capture) begin
            found_ff    <= 1'b0;
            ev_valid_ff <= 1'b0;
         end else begin
            ev_valid_ff <= cmd.scan && scan_more;
            if (take) begin
               found_ff <= 1'b1;
            end
         end
         sh_valid_ff <= cmd.shift && shift_more;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_data;
         idx_ff  <= '0;
      end else if (cmd.scan && scan_more) begin
         idx_ff <= idx_ff + CW'(1);
      end
      ev_idx_ff <= idx_ff[AW-1:0];
      if (take) begin
         pick_idx_ff   <= ev_idx_ff;
         pick_start_ff <= ent_start;
         pick_size_ff  <= ent_size;
      end
      if (cmd.carve) begin
         sh_idx_ff <= CW'(pick_idx_ff) + CW'(1);
      end else if (cmd.shift && shift_more) begin
         sh_idx_ff <= sh_idx_ff + CW'(1);
      end
      sh_dst_ff <= AW'(sh_idx_ff - CW'(1));
      if (cmd.respond) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: design/fit_policy_segment_allocator_unit.sv
// top level of the fit policy segment allocator
// An item is taken when start is high and busy is low. A load needs no scan;
// an allocate scans the free table through the single read port of its ram.
// When the chosen segment is used up, the entries above it are shifted down
// by one. The result shows on rsp_data for one cycle with rsp_valid and
// cannot be stalled. After reset busy stays high while the whole pool is
// written as entry 0.
module fit_policy_segment_allocator_unit #(
   parameter int SEGMENTS  = fpsa_pkg::SEGMENTS_DEF,
   parameter int POOL_SIZE = fpsa_pkg::POOL_SIZE_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  fpsa_pkg::req_type req_data,
   output logic              rsp_valid,
   output fpsa_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_data
);
   import fpsa_pkg::*;

   ctl_cmd_type cmd;
   ctl_sts_type sts;

   assign csr_ready = !busy;

   fpsa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .start_load (req_data.action),
      .sts        (sts),
      .cmd        (cmd),
      .busy       (busy)
   );

   fpsa_dp #(
      .SEGMENTS  (SEGMENTS),
      .POOL_SIZE (POOL_SIZE)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .csr_we    (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// File: design/fpsa_checker.sv
// port level checks of the segment allocator and their bind
module fpsa_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input fpsa_pkg::rsp_type rsp_data
);
   import fpsa_pkg::*;

   // an accepted item keeps the block busy until its result
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy low after item accepted");

   // one result per item, never two in a row
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // a result follows a busy period
   a_result_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) && !busy))
      else $error("result without a busy period");

   // failed items hand out no address
   a_fail_no_grant: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == STATUS_NOFIT ||
                     rsp_data.status == STATUS_FULL)) |-> (rsp_data.grant_address == '0))
      else $error("grant address on failed item");

endmodule

bind fit_policy_segment_allocator_unit fpsa_checker u_fpsa_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

// File: sim/fit_policy_segment_allocator_unit_tb.sv
// self-checking testbench of the fit policy segment allocator unit
`timescale 1ns / 100ps

module fit_policy_segment_allocator_unit_tb;
   import fpsa_pkg::*;

   localparam int          TABLE_DEPTH  = SEGMENTS_DEF;
   localparam int          POOL_WORDS   = POOL_SIZE_DEF;
   localparam logic [1:0]  POLICY_SPARE = 2'd3;
   localparam int          CYCLE_LIMIT  = 1000000;
   localparam int          PHASE_ITEMS  = 212;

   typedef enum logic {ROW_ITEM, ROW_POLICY} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [1:0]   policy;
      req_type      item;
      logic         typed;
      rsp_type      result;
   } plan_row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    start     = 1'b0;
   req_type req_data  = '0;
   logic    csr_valid = 1'b0;
   logic    [1:0] csr_data = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    csr_ready;

   // typed outcome traveling alongside a directed item
   logic    row_typed  = 1'b0;
   rsp_type row_result = '0;

   logic [15:0] free_base [TABLE_DEPTH];
   logic [15:0] free_size [TABLE_DEPTH];
   int unsigned free_count;
   logic [1:0]  fit_mode;

   rsp_type      grant_queue [$];
   rsp_type      predicted;
   int unsigned  mismatches = 0;
   int unsigned  cycles = 0;
   plan_row_type plan [$];

   fit_policy_segment_allocator_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic rsp_type apply_to_free_table(req_type it);
      rsp_type     r;
      int unsigned pick;
      r = '0;
      r.status = STATUS_DONE;
      if (it.action == ACTION_LOAD) begin
         if (it.segment_length != 16'd0) begin
            if (free_count >= TABLE_DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               free_base[free_count] = it.segment_base;
               free_size[free_count] = it.segment_length;
               free_count++;
            end
         end
      end else begin
         pick = free_count;
         for (int k = 0; k < free_count; k++) begin
            if (free_size[k] >= it.alloc_units) begin
               if (pick == free_count) begin
                  pick = k;
                  if (fit_mode != POLICY_BEST && fit_mode != POLICY_WORST) break;
               end else if (fit_mode == POLICY_BEST && free_size[k] < free_size[pick]) begin
                  pick = k;
               end else if (fit_mode == POLICY_WORST && free_size[k] > free_size[pick]) begin
                  pick = k;
               end
            end
         end
         if (pick == free_count) begin
            r.status = STATUS_NOFIT;
         end else begin
            r.grant_address = free_base[pick];
            free_base[pick] = free_base[pick] + it.alloc_units;
            free_size[pick] = free_size[pick] - it.alloc_units;
            if (free_size[pick] == 16'd0) begin
               for (int k = pick; k + 1 < free_count; k++) begin
                  free_base[k] = free_base[k + 1];
                  free_size[k] = free_size[k + 1];
               end
               free_count--;
            end
         end
      end
      r.segments_left = 4'(free_count);
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < TABLE_DEPTH; k++) begin
            free_base[k] = '0;
            free_size[k] = '0;
         end
         free_size[0] = 16'(POOL_WORDS);
         free_count = 1;
         fit_mode = POLICY_FIRST;
         grant_queue.delete();
      end else begin
         if (csr_valid && csr_ready) fit_mode = csr_data;
         if (start && !busy) begin
            predicted = apply_to_free_table(req_data);
            grant_queue.push_back(row_typed ? row_result : predicted);
         end
         if (rsp_valid) begin
            if (grant_queue.size() == 0) begin
               mismatches++;
               $display("%0t unexpected item: actual status %0d grant %h left %0d",
                        $time, rsp_data.status, rsp_data.grant_address,
                        rsp_data.segments_left);
            end else begin
               predicted = grant_queue.pop_front();
               if (rsp_data.status !== predicted.status) begin
                  mismatches++;
                  $display("%0t status: expected %0d actual %0d",
                           $time, predicted.status, rsp_data.status);
               end
               if (rsp_data.grant_address !== predicted.grant_address) begin
                  mismatches++;
                  $display("%0t grant_address: expected %h actual %h",
                           $time, predicted.grant_address, rsp_data.grant_address);
               end
               if (rsp_data.segments_left !== predicted.segments_left) begin
                  mismatches++;
                  $display("%0t segments_left: expected %0d actual %0d",
                           $time, predicted.segments_left, rsp_data.segments_left);
               end
            end
         end
      end
   end

   function automatic plan_row_type mk(row_kind_type kind, logic [1:0] pol, logic act,
                                       logic [15:0] rs, logic [15:0] sb, logic [15:0] sl,
                                       logic typed, logic [1:0] st, logic [15:0] ga,
                                       logic [3:0] left);
      plan_row_type row;
      row.kind = kind;
      row.policy = pol;
      row.item.action = act;
      row.item.alloc_units = rs;
      row.item.segment_base = sb;
      row.item.segment_length = sl;
      row.typed = typed;
      row.result.status = st;
      row.result.grant_address = ga;
      row.result.segments_left = left;
      return row;
   endfunction

   task automatic push_item(req_type it, logic typed, rsp_type res);
      req_data   <= it;
      row_typed  <= typed;
      row_result <= res;
      start      <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_gap(int pct);
      int n;
      n = 0;
      while (n < 60 && $urandom_range(99) < pct) n++;
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic drain;
      start <= 1'b0;
      @(posedge clock);
      while (grant_queue.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_policy(logic [1:0] pol);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= pol;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic req_type random_item();
      req_type     it;
      int unsigned pick;
      it.action = ($urandom_range(99) < 40) ? ACTION_LOAD : ACTION_ALLOC;
      it.alloc_units = 16'($urandom_range(65535));
      it.segment_base = 16'($urandom_range(65535));
      pick = $urandom_range(99);
      if (pick < 70) it.segment_length = 16'($urandom_range(64, 1));
      else if (pick < 95) it.segment_length = 16'($urandom_range(65535, 1));
      else it.segment_length = 16'd0;
      if (it.action == ACTION_ALLOC) begin
         pick = $urandom_range(99);
         if (pick < 50 && free_count > 0) begin
            it.alloc_units = free_size[$urandom_range(free_count - 1)];
         end else if (pick < 70) begin
            it.alloc_units = 16'($urandom_range(15));
         end else if (pick < 85) begin
            it.alloc_units = 16'($urandom_range(255));
         end else if (pick < 95) begin
            it.alloc_units = 16'($urandom_range(65535));
         end else begin
            it.alloc_units = 16'd0;
         end
      end
      return it;
   endfunction

   initial begin
      logic [1:0] phase_policy [8];
      int         phase_idle [8];
      phase_policy = '{POLICY_FIRST, POLICY_BEST, POLICY_WORST, POLICY_SPARE,
                       POLICY_WORST, POLICY_BEST, POLICY_FIRST, POLICY_SPARE};
      phase_idle   = '{0, 82, 8, 0, 82, 8, 82, 0};

      // zero request, oversize request, exact fit, empty table
      plan.push_back(mk(ROW_ITEM, POLICY_FIRST, ACTION_ALLOC, 16'd0, 16'd0, 16'd0,
                        1'b1, STATUS_DONE, 16'h0000, 4'd1));
      plan.push_back(mk(ROW_ITEM, POLICY_FIRST, ACTION_ALLOC, 16'hFFFF, 16'd0, 16'd0,
                        1'b1, STATUS_NOFIT, 16'h0000, 4'd1));
      plan.push_back(mk(ROW_ITEM, POLICY_FIRST, ACTION_ALLOC, 16'(POOL_WORDS), 16'd0, 16'd0,
                        1'b1, STATUS_DONE, 16'h0000, 4'd0));
      plan.push_back(mk(ROW_ITEM, POLICY_FIRST, ACTION_ALLOC, 16'd1, 16'd0, 16'd0,
                        1'b1, STATUS_NOFIT, 16'h0000, 4'd0));
      plan.push_back(mk(ROW_ITEM, POLICY_FIRST, ACTION_ALLOC, 16'd0, 16'hFFFF, 16'hFFFF,
                        1'b1, STATUS_NOFIT, 16'h0000, 4'd0));
      // zero length load, full length load, carve across address wrap
      plan.push_back(mk(ROW_ITEM, POLICY_FIRST, ACTION_LOAD, 16'hFFFF, 16'hFFFF, 16'd0,
                        1'b1, STATUS_DONE, 16'h0000, 4'd0));
      plan.push_back(mk(ROW_ITEM, POLICY_FIRST, ACTION_LOAD, 16'hFFFF, 16'hFFF0, 16'hFFFF,
                        1'b1, STATUS_DONE, 16'h0000, 4'd1));
      plan.push_back(mk(ROW_ITEM, POLICY_FIRST, ACTION_ALLOC, 16'h0020, 16'd0, 16'd0,
                        1'b1, STATUS_DONE, 16'hFFF0, 4'd1));
      // fill the table, then load into a full table
      plan.push_back(mk(ROW_ITEM, POLICY_FIRST, ACTION_LOAD, 16'd0, 16'd0, 16'd10,
                        1'b1, STATUS_DONE, 16'h0000, 4'd2));
      plan.push_back(mk(ROW_ITEM, POLICY_FIRST, ACTION_LOAD, 16'd0, 16'd100, 16'd5,
                        1'b1, STATUS_DONE, 16'h0000, 4'd3));
      plan.push_back(mk(ROW_ITEM, POLICY_FIRST, ACTION_LOAD, 16'd0, 16'd200, 16'd20,
                        1'b1, STATUS_DONE, 16'h0000, 4'd4));
      plan.push_back(mk(ROW_ITEM, POLICY_FIRST, ACTION_LOAD, 16'd0, 16'd300, 16'd5,
                        1'b1, STATUS_DONE, 16'h0000, 4'd5));
      plan.push_back(mk(ROW_ITEM, POLICY_FIRST, ACTION_LOAD, 16'd0, 16'd400, 16'd30,
                        1'b1, STATUS_DONE, 16'h0000, 4'd6));
      plan.push_back(mk(ROW_ITEM, POLICY_FIRST, ACTION_LOAD, 16'd0, 16'd500, 16'd1,
                        1'b1, STATUS_DONE, 16'h0000, 4'd7));
      plan.push_back(mk(ROW_ITEM, POLICY_FIRST, ACTION_LOAD, 16'd0, 16'd600, 16'd7,
                        1'b1, STATUS_DONE, 16'h0000, 4'd8));
      plan.push_back(mk(ROW_ITEM, POLICY_FIRST, ACTION_LOAD, 16'd0, 16'd700, 16'd9,
                        1'b1, STATUS_FULL, 16'h0000, 4'd8));
      plan.push_back(mk(ROW_ITEM, POLICY_FIRST, ACTION_LOAD, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                        1'b1, STATUS_FULL, 16'h0000, 4'd8));
      // policies, ties and shift-down on removal
      plan.push_back(mk(ROW_POLICY, POLICY_BEST, ACTION_ALLOC, 16'd0, 16'd0, 16'd0,
                        1'b0, STATUS_DONE, 16'h0000, 4'd0));
      plan.push_back(mk(ROW_ITEM, POLICY_FIRST, ACTION_ALLOC, 16'd0, 16'd0, 16'd0,
                        1'b0, STATUS_DONE, 16'h0000, 4'd0));
      plan.push_back(mk(ROW_ITEM, POLICY_FIRST, ACTION_ALLOC, 16'd5, 16'd0, 16'd0,
                        1'b0, STATUS_DONE, 16'h0000, 4'd0));
      plan.push_back(mk(ROW_POLICY, POLICY_WORST, ACTION_ALLOC, 16'd0, 16'd0, 16'd0,
                        1'b0, STATUS_DONE, 16'h0000, 4'd0));
      plan.push_back(mk(ROW_ITEM, POLICY_FIRST, ACTION_ALLOC, 16'd1, 16'd0, 16'd0,
                        1'b0, STATUS_DONE, 16'h0000, 4'd0));
      plan.push_back(mk(ROW_POLICY, POLICY_SPARE, ACTION_ALLOC, 16'd0, 16'd0, 16'd0,
                        1'b0, STATUS_DONE, 16'h0000, 4'd0));
      plan.push_back(mk(ROW_ITEM, POLICY_FIRST, ACTION_ALLOC, 16'd8, 16'd0, 16'd0,
                        1'b0, STATUS_DONE, 16'h0000, 4'd0));
      plan.push_back(mk(ROW_POLICY, POLICY_FIRST, ACTION_ALLOC, 16'd0, 16'd0, 16'd0,
                        1'b0, STATUS_DONE, 16'h0000, 4'd0));
      plan.push_back(mk(ROW_ITEM, POLICY_FIRST, ACTION_ALLOC, 16'd1, 16'd0, 16'd0,
                        1'b0, STATUS_DONE, 16'h0000, 4'd0));

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_POLICY) write_policy(plan[i].policy);
         else push_item(plan[i].item, plan[i].typed, plan[i].result);
      end

      for (int ph = 0; ph < 8; ph++) begin
         write_policy(phase_policy[ph]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            idle_gap(phase_idle[ph]);
            push_item(random_item(), 1'b0, '0);
         end
      end

      start <= 1'b0;
      @(posedge clock);
      while (grant_queue.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: files.f
design/fpsa_pkg.sv
design/fpsa_ram.sv
design/fpsa_ctrl.sv
design/fpsa_dp.sv
design/fit_policy_segment_allocator_unit.sv
design/fpsa_checker.sv
sim/fit_policy_segment_allocator_unit_tb.sv
